>>> design/pbm_pkg.sv
package pbm_pkg;

    localparam int KW    = 48;   // coefficient width, Q16.32
    localparam int FRAC  = 32;   // fraction bits of a coefficient
    localparam int AW    = 97;   // adjugate entry
    localparam int DETW  = 147;  // determinant
    localparam int ACW   = 150;  // serial multiply accumulator
    localparam int XW    = 10;   // pixel coordinate
    localparam int PW    = 107;  // adjugate times coordinate
    localparam int UW    = 109;  // u, v, w
    localparam int SW    = 150;  // numerator / denominator, signed
    localparam int LW    = 164;  // divider remainder
    localparam int QW    = 13;   // quotient bits
    localparam int NCOEF = 8;
    localparam int NADJ  = 9;
    localparam int NSTEP = 21;
    localparam int DW    = 64;
    localparam int PAW   = 6;

    localparam int IMG_W_DEF = 1024;
    localparam int IMG_H_DEF = 1024;

    localparam logic [KW-1:0] ONE_Q32 = KW'(64'h1_0000_0000);
    localparam logic [3:0]    K_ONE   = 4'd8;

    typedef struct packed {
        logic [3:0] a_idx;
        logic [3:0] b_idx;
        logic       b_adj;
        logic       neg;
    } t_op;

    typedef struct packed {
        logic [NADJ-1:0][AW-1:0] adj;
        logic [DETW-1:0]         det;
        logic                    sing;
    } t_mat;

    typedef struct packed {
        logic [LW-1:0] rem;
        logic [LW-1:0] dd;
        logic [QW-1:0] q;
        logic          neg;
        logic          sub_half;
        logic          over;
    } t_lane;

    typedef struct packed {
        logic  v;
        t_lane lx;
        t_lane ly;
    } t_stage;

    // adj[j] = k[p]*k[q] - k[r]*k[s], then det = k0*a0 + k1*a3 + k2*a6
    function automatic t_op step_op(input logic [4:0] s);
        t_op o;
        unique case (s)
            5'd0:  o = '{4'd4, 4'd8, 1'b0, 1'b0};
            5'd1:  o = '{4'd5, 4'd7, 1'b0, 1'b1};
            5'd2:  o = '{4'd2, 4'd7, 1'b0, 1'b0};
            5'd3:  o = '{4'd1, 4'd8, 1'b0, 1'b1};
            5'd4:  o = '{4'd1, 4'd5, 1'b0, 1'b0};
            5'd5:  o = '{4'd2, 4'd4, 1'b0, 1'b1};
            5'd6:  o = '{4'd5, 4'd6, 1'b0, 1'b0};
            5'd7:  o = '{4'd3, 4'd8, 1'b0, 1'b1};
            5'd8:  o = '{4'd0, 4'd8, 1'b0, 1'b0};
            5'd9:  o = '{4'd2, 4'd6, 1'b0, 1'b1};
            5'd10: o = '{4'd2, 4'd3, 1'b0, 1'b0};
            5'd11: o = '{4'd0, 4'd5, 1'b0, 1'b1};
            5'd12: o = '{4'd3, 4'd7, 1'b0, 1'b0};
            5'd13: o = '{4'd4, 4'd6, 1'b0, 1'b1};
            5'd14: o = '{4'd1, 4'd6, 1'b0, 1'b0};
            5'd15: o = '{4'd0, 4'd7, 1'b0, 1'b1};
            5'd16: o = '{4'd0, 4'd4, 1'b0, 1'b0};
            5'd17: o = '{4'd1, 4'd3, 1'b0, 1'b1};
            5'd18: o = '{4'd0, 4'd0, 1'b1, 1'b0};
            5'd19: o = '{4'd1, 4'd3, 1'b1, 1'b0};
            5'd20: o = '{4'd2, 4'd6, 1'b1, 1'b0};
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

>>> design/pbm_if.sv
interface pbm_in_if;
    logic          valid;
    logic          ready;
    logic [9:0]    out_x;
    logic [9:0]    out_y;
    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface pbm_out_if;
    logic          valid;
    logic          ready;
    logic [9:0]    src_x;
    logic [9:0]    src_y;
    logic          in_bounds;
    modport source (output valid, output src_x, output src_y, output in_bounds, input ready);
    modport sink   (input valid, input src_x, input src_y, input in_bounds, output ready);
endinterface

>>> design/pbm_cfg.sv
module pbm_cfg import pbm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [DW-1:0]  pwdata,
    output logic [DW-1:0]  prdata,
    output logic           o_busy,
    output t_mat           o_mat
);

    logic [KW-1:0]   r_coef [NCOEF];
    logic [AW-1:0]   r_adj  [NADJ];
    logic [DETW-1:0] r_det;
    logic            r_busy;
    logic [4:0]      r_step;
    logic [5:0]      r_bit;
    logic [ACW-1:0]  r_acc;
    logic [ACW-1:0]  r_mb;

    logic            wr;
    logic [2:0]      widx;
    t_op             op;
    logic [KW-1:0]   opa;
    logic [ACW-1:0]  b_ext;
    logic [ACW-1:0]  mb_cur;
    logic [ACW-1:0]  term;
    logic [ACW-1:0]  acc_nx;

    assign wr   = psel & penable & pwrite;
    assign widx = paddr[PAW-1:3];
    assign prdata = DW'($signed(r_coef[widx]));

    // shift-add multiply, one bit of the 48-bit operand per cycle
    always_comb begin
        op  = step_op(r_step);
        opa = (op.a_idx == K_ONE) ? ONE_Q32 : r_coef[op.a_idx[2:0]];
        if (op.b_adj) begin
            b_ext = ACW'($signed(r_adj[op.b_idx]));
        end else if (op.b_idx == K_ONE) begin
            b_ext = ACW'(ONE_Q32);
        end else begin
            b_ext = ACW'($signed(r_coef[op.b_idx[2:0]]));
        end
        if (op.neg) begin
            b_ext = -b_ext;
        end
        mb_cur = (r_bit == '0) ? b_ext : r_mb;
        term   = '0;
        if (opa[r_bit]) begin
            term = (r_bit == 6'(KW-1)) ? -mb_cur : mb_cur;
        end
        acc_nx = r_acc + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[0] <= ONE_Q32;
            r_coef[4] <= ONE_Q32;
            r_busy    <= 1'b1;
            r_step    <= '0;
            r_bit     <= '0;
            r_acc     <= '0;
        end else if (wr) begin
            r_coef[widx] <= pwdata[KW-1:0];
            r_busy       <= 1'b1;
            r_step       <= '0;
            r_bit        <= '0;
            r_acc        <= '0;
        end else if (r_busy) begin
            r_mb <= mb_cur << 1;
            if (r_bit == 6'(KW-1)) begin
                r_bit  <= '0;
                r_step <= r_step + 5'd1;
                if (r_step == 5'(NSTEP-1)) begin
                    r_det  <= acc_nx[DETW-1:0];
                    r_busy <= 1'b0;
                end
                if (r_step[0] && r_step < 5'(2*NADJ)) begin
                    r_adj[r_step[4:1]] <= acc_nx[AW-1:0];
                    r_acc              <= '0;
                end else begin
                    r_acc <= acc_nx;
                end
            end else begin
                r_bit <= r_bit + 6'd1;
                r_acc <= acc_nx;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NADJ; j++) begin
            o_mat.adj[j] = r_adj[j];
        end
        o_mat.det  = r_det;
        o_mat.sing = (r_det == '0);
    end

    assign o_busy = r_busy;

endmodule

>>> design/pbm_div_cell.sv
module pbm_div_cell import pbm_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_d,
    output t_stage o_d
);

    t_stage r_d;
    t_stage n_d;

    function automatic t_lane lane_step(input t_lane l);
        t_lane         o;
        logic [LW-1:0] s;
        o = l;
        s = l.dd << BIT;
        if (l.rem >= s) begin
            o.rem    = l.rem - s;
            o.q[BIT] = 1'b1;
        end
        return o;
    endfunction

    always_comb begin
        n_d    = i_d;
        n_d.lx = lane_step(i_d.lx);
        n_d.ly = lane_step(i_d.ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.v <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> design/perspective_backward_map_nearest_top.sv
// channel   dir  signals                          item
// i_pix     in   valid ready out_x out_y          one output pixel position
// o_src     out  valid ready src_x src_y in_bnds  one source pixel position
// apb       in   psel penable pwrite paddr pwdata  coefficient write, 8 x 48 bit
//
// One item per cycle while o_src takes results and the multiplier is not busy.
// After reset and after every coefficient write, a serial shift-add multiplier
// forms the adjugate and determinant from 21 products, with i_pix.ready low
// meanwhile. Reset is synchronous, active low.
// The whole pipe holds when o_src is full and not taken.
module perspective_backward_map_nearest_top import pbm_pkg::*; #(
    parameter int IMAGE_WIDTH  = IMG_W_DEF,
    parameter int IMAGE_HEIGHT = IMG_H_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pbm_in_if.sink         i_pix,
    pbm_out_if.source      o_src,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [DW-1:0]  pwdata,
    output logic [DW-1:0]  prdata,
    output logic           pready
);

    t_mat mat;
    logic busy;
    logic en;

    logic                 r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [XW-1:0]        r_x, r_y;
    logic signed [PW-1:0] r_p [6];
    logic signed [UW-1:0] r_u, r_v, r_w;
    logic [SW-1:0]        r_mnx, r_mny, r_md;
    logic                 r_ngx, r_ngy;
    t_lane                r_s4x, r_s4y, r_s5x, r_s5y;
    t_stage               c_st [QW+1];

    logic                 r_out_v;
    logic [XW-1:0]        r_sx, r_sy;
    logic                 r_ib;

    logic                 wz;
    logic [SW-1:0]        den, numx, numy;
    logic                 okx, oky, ok;
    t_lane                fx, fy;
    t_lane                n_s5x, n_s5y;

    assign pready = 1'b1;

    pbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_busy  (busy),
        .o_mat   (mat)
    );

    assign en          = !r_out_v || o_src.ready;
    assign i_pix.ready = en && !busy;

    always_comb begin
        wz   = (r_w == '0);
        den  = wz ? SW'($signed(mat.det)) : SW'(r_w);
        numx = wz ? (SW'(r_u) << FRAC) : SW'(r_u);
        numy = wz ? (SW'(r_v) << FRAC) : SW'(r_v);
    end

    always_comb begin
        n_s5x          = r_s4x;
        n_s5x.sub_half = r_s4x.rem < r_s4x.dd;
        n_s5x.over     = r_s4x.rem >= (r_s4x.dd << QW);
        n_s5y          = r_s4y;
        n_s5y.sub_half = r_s4y.rem < r_s4y.dd;
        n_s5y.over     = r_s4y.rem >= (r_s4y.dd << QW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v0    <= i_pix.valid && i_pix.ready;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_out_v <= c_st[QW].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= i_pix.out_x;
            r_y <= i_pix.out_y;

            r_p[0] <= PW'($signed(mat.adj[0])) * PW'($signed({1'b0, r_x}));
            r_p[1] <= PW'($signed(mat.adj[1])) * PW'($signed({1'b0, r_y}));
            r_p[2] <= PW'($signed(mat.adj[3])) * PW'($signed({1'b0, r_x}));
            r_p[3] <= PW'($signed(mat.adj[4])) * PW'($signed({1'b0, r_y}));
            r_p[4] <= PW'($signed(mat.adj[6])) * PW'($signed({1'b0, r_x}));
            r_p[5] <= PW'($signed(mat.adj[7])) * PW'($signed({1'b0, r_y}));

            r_u <= UW'(r_p[0]) + UW'(r_p[1]) + UW'($signed(mat.adj[2]));
            r_v <= UW'(r_p[2]) + UW'(r_p[3]) + UW'($signed(mat.adj[5]));
            r_w <= UW'(r_p[4]) + UW'(r_p[5]) + UW'($signed(mat.adj[8]));

            r_mnx <= numx[SW-1] ? -numx : numx;
            r_mny <= numy[SW-1] ? -numy : numy;
            r_md  <= den[SW-1] ? -den : den;
            r_ngx <= (numx[SW-1] != den[SW-1]) && (numx != '0);
            r_ngy <= (numy[SW-1] != den[SW-1]) && (numy != '0);

            r_s4x.rem      <= (LW'(r_mnx) << 1) + LW'(r_md);
            r_s4x.dd       <= LW'(r_md) << 1;
            r_s4x.q        <= '0;
            r_s4x.neg      <= r_ngx;
            r_s4x.sub_half <= 1'b0;
            r_s4x.over     <= 1'b0;
            r_s4y.rem      <= (LW'(r_mny) << 1) + LW'(r_md);
            r_s4y.dd       <= LW'(r_md) << 1;
            r_s4y.q        <= '0;
            r_s4y.neg      <= r_ngy;
            r_s4y.sub_half <= 1'b0;
            r_s4y.over     <= 1'b0;

            r_s5x <= n_s5x;
            r_s5y <= n_s5y;

            r_sx <= ok && !mat.sing ? fx.q[XW-1:0] : '0;
            r_sy <= ok && !mat.sing ? fy.q[XW-1:0] : '0;
            r_ib <= ok || mat.sing;
        end
    end

    assign c_st[0] = '{v: r_v5, lx: r_s5x, ly: r_s5y};

    for (genvar g = 0; g < QW; g++) begin : g_cell
        pbm_div_cell #(.BIT(QW-1-g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (c_st[g]),
            .o_d     (c_st[g+1])
        );
    end

    always_comb begin
        fx  = c_st[QW].lx;
        fy  = c_st[QW].ly;
        okx = fx.neg ? fx.sub_half
                     : (!fx.over && ({1'b0, fx.q} < (QW+1)'(IMAGE_WIDTH)));
        oky = fy.neg ? fy.sub_half
                     : (!fy.over && ({1'b0, fy.q} < (QW+1)'(IMAGE_HEIGHT)));
        ok  = okx && oky;
    end

    assign o_src.valid     = r_out_v;
    assign o_src.src_x     = r_sx;
    assign o_src.src_y     = r_sy;
    assign o_src.in_bounds = r_ib;

endmodule

>>> design/pbm_chk.sv
module pbm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_src_x,
    input logic [9:0] i_src_y,
    input logic       i_in_bounds,
    input logic       i_cfg_wr
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_src_x)
            && $stable(i_src_y) && $stable(i_in_bounds))
        else $error("result changed while stalled");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_in_bounds |-> i_src_x == 10'd0 && i_src_y == 10'd0)
        else $error("out of bounds item with nonzero coordinates");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> !i_in_ready)
        else $error("input ready right after coefficient write");

endmodule

bind perspective_backward_map_nearest_top pbm_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_src.valid),
    .i_out_ready (o_src.ready),
    .i_src_x     (o_src.src_x),
    .i_src_y     (o_src.src_y),
    .i_in_bounds (o_src.in_bounds),
    .i_cfg_wr    (psel & penable & pwrite)
);
